[src/tdd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tdd_pkg;

    // Default number of task slots in the scoreboard.
    localparam int TASK_SLOTS_DEF = 16;

    // Fixed field widths.
    localparam int DEP_W  = 16;
    localparam int SLOT_W = 4;

    // Slot status codes.
    localparam logic [2:0] ST_ABSENT   = 3'd0;
    localparam logic [2:0] ST_PENDING  = 3'd1;
    localparam logic [2:0] ST_READY    = 3'd2;
    localparam logic [2:0] ST_RUNNING  = 3'd3;
    localparam logic [2:0] ST_COMPLETE = 3'd4;
    localparam logic [2:0] ST_FAILED   = 3'd5;

    // Action codes of an input transaction.
    localparam logic [2:0] ACT_CLEAR  = 3'd0;
    localparam logic [2:0] ACT_ADD    = 3'd1;
    localparam logic [2:0] ACT_RETRY  = 3'd2;
    localparam logic [2:0] ACT_RESUME = 3'd3;
    localparam logic [2:0] ACT_FINISH = 3'd4;
    localparam logic [2:0] ACT_FAIL   = 3'd5;

    // Result kinds.
    localparam logic [1:0] KIND_DISPATCH = 2'd0;
    localparam logic [1:0] KIND_FINISHED = 2'd1;
    localparam logic [1:0] KIND_ESCALATE = 2'd2;

    // Input transaction payload.
    typedef struct packed {
        logic [2:0]        action;
        logic [SLOT_W-1:0] task_index;
        logic [DEP_W-1:0]  dep_mask;
    } cmd_t;

    // Result transaction payload.
    typedef struct packed {
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic              running_now;
        logic              last;
    } res_t;

    // Write controls from the sequencer to the slot table.
    typedef struct packed {
        logic       clr;
        logic       wr_en;
        logic [2:0] wr_status;
        logic       dep_wr_en;
    } tbl_ctl_t;

endpackage

`default_nettype wire

[src/tdd_dep_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Shared dependency check: decides for one slot whether it is dispatched.
module tdd_dep_unit (
    input  wire logic [2:0]               status,
    input  wire logic [tdd_pkg::DEP_W-1:0] deps,
    input  wire logic [tdd_pkg::DEP_W-1:0] complete_vec,
    output logic                          dispatch,
    output logic [2:0]                    post_status
);

    logic deps_met;

    // A dependency is met only when its slot exists and is Complete.
    assign deps_met = ((deps & ~complete_vec) == '0);

    // Ready slots and Pending slots with all dependencies met start running.
    always_comb
    begin
        dispatch = (status == tdd_pkg::ST_READY) ||
                   ((status == tdd_pkg::ST_PENDING) && deps_met);
        post_status = dispatch ? tdd_pkg::ST_RUNNING : status;
    end

endmodule

`default_nettype wire

[src/tdd_slot_table.sv]
`timescale 1ns / 1ps
`default_nettype none

// Slot status flops and the dependency mask memory.
module tdd_slot_table #(
    parameter int TASK_SLOTS = tdd_pkg::TASK_SLOTS_DEF,
    parameter int IDX_W      = $clog2(TASK_SLOTS)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tdd_pkg::tbl_ctl_t             ctl,
    input  wire logic [IDX_W-1:0]              wr_idx,
    input  wire logic [tdd_pkg::SLOT_W-1:0]    dep_wr_addr,
    input  wire logic [tdd_pkg::DEP_W-1:0]     dep_wr_data,
    input  wire logic [tdd_pkg::SLOT_W-1:0]    dep_rd_addr,
    input  wire logic [IDX_W-1:0]              cmd_idx,
    input  wire logic [IDX_W-1:0]              walk_idx,
    output logic [2:0]                         cmd_status,
    output logic [2:0]                         walk_status,
    output logic [tdd_pkg::DEP_W-1:0]          dep_rd_data,
    output logic [tdd_pkg::DEP_W-1:0]          complete_vec
);

    localparam int DEP_DEPTH = 1 << tdd_pkg::SLOT_W;

    logic [2:0]                     status_reg [TASK_SLOTS];
    logic [tdd_pkg::DEP_W-1:0]      dep_mem [DEP_DEPTH];
    logic [tdd_pkg::DEP_W-1:0]      dep_rd_reg;

    // Status table: clear empties every slot, otherwise one slot is written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                status_reg[i] <= tdd_pkg::ST_ABSENT;
            end
        end
        else if (ctl.clr)
        begin
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                status_reg[i] <= tdd_pkg::ST_ABSENT;
            end
        end
        else if (ctl.wr_en)
        begin
            status_reg[wr_idx] <= ctl.wr_status;
        end
    end

    // Dependency memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.dep_wr_en)
        begin
            dep_mem[dep_wr_addr] <= dep_wr_data;
        end
        dep_rd_reg <= dep_mem[dep_rd_addr];
    end

    assign dep_rd_data = dep_rd_reg;
    assign cmd_status  = status_reg[cmd_idx];
    assign walk_status = status_reg[walk_idx];

    // Complete flags for the slots a dependency mask can name.
    for (genvar j = 0; j < tdd_pkg::DEP_W; j++)
    begin : g_complete
        if (j < TASK_SLOTS)
        begin : g_slot
            assign complete_vec[j] = (status_reg[j] == tdd_pkg::ST_COMPLETE);
        end
        else
        begin : g_none
            assign complete_vec[j] = 1'b0;
        end
    end

endmodule

`default_nettype wire

[src/task_dependency_dispatcher.sv]
`timescale 1ns / 1ps
`default_nettype none

// Clear, add and retry give no result; fail on a present slot gives its escalate
// result in the cycle after acceptance. Resume and evaluating finish keep busy high
// while one shared dependency check walks the slots one per cycle, then a closing
// step; dispatches appear during the walk and the last result, if any, is registered
// in the closing step. A new transaction is taken once busy is low. The receiver
// cannot stall. Reset empties the table and clears the running flag.
module task_dependency_dispatcher #(
    parameter int TASK_SLOTS = tdd_pkg::TASK_SLOTS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire tdd_pkg::cmd_t command,
    output logic               busy,
    output tdd_pkg::res_t      result,
    output logic               result_valid
);

    localparam int IDX_W = $clog2(TASK_SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } state_t;

    state_t                       state_reg, state_next;
    logic [IDX_W-1:0]             walk_reg, walk_next;
    logic                         hold_valid_reg, hold_valid_next;
    logic [IDX_W-1:0]             hold_slot_reg, hold_slot_next;
    logic                         any_reg, any_next;
    logic                         all_done_reg, all_done_next;
    logic                         running_reg, running_next;
    tdd_pkg::res_t                res_reg, res_next;
    logic                         res_valid_reg, res_valid_next;

    tdd_pkg::tbl_ctl_t            ctl;
    logic [IDX_W-1:0]             wr_idx;
    logic [IDX_W-1:0]             cmd_idx;
    logic [tdd_pkg::SLOT_W-1:0]   dep_rd_addr;
    logic [2:0]                   cmd_status;
    logic [2:0]                   walk_status;
    logic [tdd_pkg::DEP_W-1:0]    dep_rd_data;
    logic [tdd_pkg::DEP_W-1:0]    complete_vec;
    logic                         dispatch;
    logic [2:0]                   post_status;
    logic [IDX_W:0]               walk_inc;
    logic                         accept;
    logic                         cmd_valid;
    logic                         present;
    logic                         begin_walk;

    assign cmd_idx  = IDX_W'(command.task_index);
    assign walk_inc = {1'b0, walk_reg} + 1'b1;

    tdd_slot_table #(
        .TASK_SLOTS (TASK_SLOTS),
        .IDX_W      (IDX_W)
    ) u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .wr_idx       (wr_idx),
        .dep_wr_addr  (command.task_index),
        .dep_wr_data  (command.dep_mask),
        .dep_rd_addr  (dep_rd_addr),
        .cmd_idx      (cmd_idx),
        .walk_idx     (walk_reg),
        .cmd_status   (cmd_status),
        .walk_status  (walk_status),
        .dep_rd_data  (dep_rd_data),
        .complete_vec (complete_vec)
    );

    tdd_dep_unit u_dep (
        .status       (walk_status),
        .deps         (dep_rd_data),
        .complete_vec (complete_vec),
        .dispatch     (dispatch),
        .post_status  (post_status)
    );

    // Sequencer: decode the action, walk the slots, then close the evaluation.
    always_comb
    begin
        accept     = start && (state_reg == S_IDLE);
        cmd_valid  = 32'(command.task_index) < 32'(TASK_SLOTS);
        present    = cmd_valid && (cmd_status != tdd_pkg::ST_ABSENT);
        begin_walk = 1'b0;

        ctl             = '0;
        wr_idx          = cmd_idx;
        dep_rd_addr     = '0;
        state_next      = state_reg;
        walk_next       = walk_reg;
        hold_valid_next = hold_valid_reg;
        hold_slot_next  = hold_slot_reg;
        any_next        = any_reg;
        all_done_next   = all_done_reg;
        running_next    = running_reg;
        res_next        = res_reg;
        res_valid_next  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (command.action)
                        tdd_pkg::ACT_CLEAR:
                        begin
                            ctl.clr = 1'b1;
                        end
                        tdd_pkg::ACT_ADD:
                        begin
                            if (cmd_valid)
                            begin
                                ctl.wr_en     = 1'b1;
                                ctl.dep_wr_en = 1'b1;
                                ctl.wr_status = (command.dep_mask == '0) ?
                                                tdd_pkg::ST_READY : tdd_pkg::ST_PENDING;
                            end
                        end
                        tdd_pkg::ACT_RETRY:
                        begin
                            if (present)
                            begin
                                ctl.wr_en     = 1'b1;
                                ctl.wr_status = tdd_pkg::ST_PENDING;
                            end
                        end
                        tdd_pkg::ACT_RESUME:
                        begin
                            running_next = 1'b1;
                            begin_walk   = 1'b1;
                        end
                        tdd_pkg::ACT_FINISH:
                        begin
                            if (present && (cmd_status != tdd_pkg::ST_COMPLETE))
                            begin
                                ctl.wr_en     = 1'b1;
                                ctl.wr_status = tdd_pkg::ST_COMPLETE;
                                begin_walk    = 1'b1;
                            end
                        end
                        tdd_pkg::ACT_FAIL:
                        begin
                            if (present)
                            begin
                                ctl.wr_en            = 1'b1;
                                ctl.wr_status        = tdd_pkg::ST_FAILED;
                                running_next         = 1'b0;
                                res_next.kind        = tdd_pkg::KIND_ESCALATE;
                                res_next.slot        = command.task_index;
                                res_next.running_now = 1'b0;
                                res_next.last        = 1'b1;
                                res_valid_next       = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (begin_walk)
                begin
                    state_next      = S_WALK;
                    walk_next       = '0;
                    hold_valid_next = 1'b0;
                    any_next        = 1'b0;
                    all_done_next   = 1'b1;
                end
            end

            S_WALK:
            begin
                // Prefetch the next slot's dependency mask.
                wr_idx      = walk_reg;
                dep_rd_addr = tdd_pkg::SLOT_W'(walk_inc);
                if (dispatch)
                begin
                    ctl.wr_en     = 1'b1;
                    ctl.wr_status = tdd_pkg::ST_RUNNING;
                    // A held dispatch is not the last once another one follows.
                    if (hold_valid_reg)
                    begin
                        res_next.kind        = tdd_pkg::KIND_DISPATCH;
                        res_next.slot        = tdd_pkg::SLOT_W'(hold_slot_reg);
                        res_next.running_now = running_reg;
                        res_next.last        = 1'b0;
                        res_valid_next       = 1'b1;
                    end
                    hold_valid_next = 1'b1;
                    hold_slot_next  = walk_reg;
                end
                any_next      = any_reg || (post_status != tdd_pkg::ST_ABSENT);
                all_done_next = all_done_reg &&
                                ((post_status == tdd_pkg::ST_ABSENT) ||
                                 (post_status == tdd_pkg::ST_COMPLETE));
                if (walk_reg == IDX_W'(TASK_SLOTS - 1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    walk_next = walk_inc[IDX_W-1:0];
                end
            end

            S_FINISH:
            begin
                if (hold_valid_reg)
                begin
                    res_next.kind        = tdd_pkg::KIND_DISPATCH;
                    res_next.slot        = tdd_pkg::SLOT_W'(hold_slot_reg);
                    res_next.running_now = running_reg;
                    res_next.last        = 1'b1;
                    res_valid_next       = 1'b1;
                end
                else if (any_reg && all_done_reg)
                begin
                    // Every present task is done: report and empty the table.
                    ctl.clr              = 1'b1;
                    running_next         = 1'b0;
                    res_next.kind        = tdd_pkg::KIND_FINISHED;
                    res_next.slot        = '0;
                    res_next.running_now = 1'b0;
                    res_next.last        = 1'b1;
                    res_valid_next       = 1'b1;
                end
                hold_valid_next = 1'b0;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            walk_reg       <= '0;
            hold_valid_reg <= 1'b0;
            any_reg        <= 1'b0;
            all_done_reg   <= 1'b1;
            running_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            walk_reg       <= walk_next;
            hold_valid_reg <= hold_valid_next;
            any_reg        <= any_next;
            all_done_reg   <= all_done_next;
            running_reg    <= running_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        hold_slot_reg <= hold_slot_next;
        res_reg       <= res_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result       = res_reg;
    assign result_valid = res_valid_reg;

    // An escalate result always reports a stopped workflow and ends its transaction.
    a_escalate_form: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == tdd_pkg::KIND_ESCALATE)
        |-> !result.running_now && result.last)
        else $error("escalate result with running set or not last");

    // A finished result names slot zero, is last, and comes with the running flag clear and no slot complete.
    a_finished_form: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == tdd_pkg::KIND_FINISHED)
        |-> (result.slot == '0) && result.last && !running_reg && (complete_vec == '0))
        else $error("malformed finished result");

    // No dispatch is held over once the block is idle.
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !hold_valid_reg)
        else $error("held dispatch left behind in idle");

    // Every dispatch result reflects the running flag at the time it is given.
    a_dispatch_running: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == tdd_pkg::KIND_DISPATCH)
        |-> (result.running_now == running_reg))
        else $error("dispatch running flag mismatch");

    // A walk always ends through the closing step before the next transaction.
    a_walk_close: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) && (walk_reg == IDX_W'(TASK_SLOTS - 1))
        |=> (state_reg == S_FINISH))
        else $error("walk did not close");

endmodule

`default_nettype wire

[tb/sv/dispatch_checker.sv]
`timescale 1ns / 1ps

// Watches the command and result channels of the dispatcher, keeps its own
// copy of the task table and compares every result with the oldest one due.
module dispatch_checker
    import tdd_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t command,
    input  logic busy,
    input  res_t result,
    input  logic result_valid,
    output int   mismatches,
    output int   outstanding
);

    // Shadow of the scoreboard.
    logic [2:0]       slot_state [TASK_SLOTS];
    logic [DEP_W-1:0] slot_needs [TASK_SLOTS];
    logic             wf_running;

    // Results still owed by the block, oldest first, and those of the current command.
    res_t due_results [$];
    res_t this_round [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic res_t make_result(input logic [1:0] kind, input int slot);
        res_t r;
        r.kind        = kind;
        r.slot        = SLOT_W'(slot);
        r.running_now = wf_running;
        r.last        = 1'b0;
        return r;
    endfunction

    // A dependency on a slot outside the table, or on one not yet complete, blocks.
    function automatic logic needs_met(input logic [DEP_W-1:0] needs);
        for (int j = 0; j < DEP_W; j++)
        begin
            if (needs[j] && (j >= TASK_SLOTS || slot_state[j] != ST_COMPLETE))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Launch every ready slot in index order, then retire the workflow if all is done.
    task automatic evaluate_table();
        logic any_present;
        logic all_done;
        any_present = 1'b0;
        all_done    = 1'b1;
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            if (slot_state[i] == ST_PENDING && needs_met(slot_needs[i]))
                slot_state[i] = ST_READY;
            if (slot_state[i] == ST_READY)
            begin
                slot_state[i] = ST_RUNNING;
                if (this_round.size() < 16)
                    this_round.push_back(make_result(KIND_DISPATCH, i));
            end
        end
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            if (slot_state[i] != ST_ABSENT)
            begin
                any_present = 1'b1;
                if (slot_state[i] != ST_COMPLETE)
                    all_done = 1'b0;
            end
        end
        if (any_present && all_done)
        begin
            wf_running = 1'b0;
            foreach (slot_state[i])
                slot_state[i] = ST_ABSENT;
            this_round.push_back(make_result(KIND_FINISHED, 0));
        end
    endtask

    // Update the shadow table for one accepted command and queue what it owes.
    task automatic apply_command(input cmd_t c);
        logic in_range;
        logic present;
        res_t r;
        in_range = int'(c.task_index) < TASK_SLOTS;
        present  = in_range && slot_state[c.task_index] != ST_ABSENT;
        this_round.delete();
        case (c.action)
            ACT_CLEAR:
            begin
                foreach (slot_state[i])
                    slot_state[i] = ST_ABSENT;
            end
            ACT_ADD:
            begin
                if (in_range)
                begin
                    slot_needs[c.task_index] = c.dep_mask;
                    slot_state[c.task_index] = (c.dep_mask == '0) ? ST_READY : ST_PENDING;
                end
            end
            ACT_RETRY:
            begin
                if (present)
                    slot_state[c.task_index] = ST_PENDING;
            end
            ACT_RESUME:
            begin
                wf_running = 1'b1;
                evaluate_table();
            end
            ACT_FINISH:
            begin
                if (present && slot_state[c.task_index] != ST_COMPLETE)
                begin
                    slot_state[c.task_index] = ST_COMPLETE;
                    evaluate_table();
                end
            end
            ACT_FAIL:
            begin
                if (present)
                begin
                    slot_state[c.task_index] = ST_FAILED;
                    wf_running = 1'b0;
                    this_round.push_back(make_result(KIND_ESCALATE, int'(c.task_index)));
                end
            end
            default:
            begin
            end
        endcase
        if (this_round.size() > 0)
        begin
            r = this_round.pop_back();
            r.last = 1'b1;
            this_round.push_back(r);
        end
        foreach (this_round[i])
            due_results.push_back(this_round[i]);
    endtask

    // Compare results first, then predict from the transaction accepted at this edge.
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            foreach (slot_state[i])
            begin
                slot_state[i] = ST_ABSENT;
                slot_needs[i] = '0;
            end
            wf_running = 1'b0;
            due_results.delete();
        end
        else
        begin
            if (result_valid)
            begin
                if (due_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d slot %0d running_now %0b last %0b",
                           result.kind, result.slot, result.running_now, result.last);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, result.kind);
                        mismatches++;
                    end
                    if (result.slot !== want.slot)
                    begin
                        $error("slot: expected %0d, got %0d", want.slot, result.slot);
                        mismatches++;
                    end
                    if (result.running_now !== want.running_now)
                    begin
                        $error("running_now: expected %0b, got %0b",
                               want.running_now, result.running_now);
                        mismatches++;
                    end
                    if (result.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, result.last);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                apply_command(command);
        end
        outstanding = due_results.size();
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

// Drives command transactions into the dispatcher: a directed walk through the
// corner cases, then random workflows built as dependency graphs, mixed with noise.
module tb;
    import tdd_pkg::*;

    localparam int SLOTS      = TASK_SLOTS_DEF;
    localparam int ITEM_GOAL  = 230;
    localparam int CYCLE_CAP  = 200000;
    localparam int QUIET_FROM = 110;
    localparam int QUIET_TO   = 170;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    cmd_t command = '0;
    logic busy;
    res_t result;
    logic result_valid;
    int   mismatches;
    int   outstanding;
    int   issued = 0;
    int   cycles = 0;

    always #10 clk = ~clk;

    task_dependency_dispatcher #(
        .TASK_SLOTS(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .command(command),
        .busy(busy),
        .result(result),
        .result_valid(result_valid)
    );

    dispatch_checker #(
        .TASK_SLOTS(SLOTS)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .command(command),
        .busy(busy),
        .result(result),
        .result_valid(result_valid),
        .mismatches(mismatches),
        .outstanding(outstanding)
    );

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Present one command, with an occasional idle gap ahead of it, and wait for acceptance.
    task automatic send(input logic [2:0] act, input int idx, input logic [DEP_W-1:0] mask);
        int gap;
        if ((issued < QUIET_FROM || issued >= QUIET_TO) && $urandom_range(0, 99) < 32)
        begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        command <= '{action: act, task_index: SLOT_W'(idx), dep_mask: mask};
        while (busy)
            @(negedge clk);
        @(posedge clk);
        if (act <= ACT_FAIL)
            issued++;
    endtask

    // A workflow, with occasional noise mixed in: add a graph of tasks, start it, finish every task.
    task automatic run_workflow();
        int                count;
        int                idx;
        int                pick;
        int                tmp;
        int                order [$];
        logic [SLOTS-1:0]  used;
        logic [DEP_W-1:0]  mask;
        if ($urandom_range(0, 3) != 0)
            send(ACT_CLEAR, $urandom_range(0, 15), DEP_W'($urandom));
        count = ($urandom_range(0, 9) == 0) ? SLOTS : $urandom_range(1, 8);
        used  = '0;
        for (int k = 0; k < count; k++)
        begin
            do
                idx = $urandom_range(0, SLOTS - 1);
            while (used[idx]);
            mask = DEP_W'($urandom) & DEP_W'(used);
            if ($urandom_range(0, 3) == 0)
                mask = '0;
            else if ($urandom_range(0, 11) == 0)
                mask = DEP_W'($urandom);
            used[idx] = 1'b1;
            order.push_back(idx);
            send(ACT_ADD, idx, mask);
        end
        send(ACT_RESUME, $urandom_range(0, 15), DEP_W'($urandom));
        // Finish in a shuffled order.
        for (int k = order.size() - 1; k > 0; k--)
        begin
            pick = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[pick];
            order[pick] = tmp;
        end
        foreach (order[k])
        begin
            case ($urandom_range(0, 15))
                0: send(ACT_FAIL, order[k], DEP_W'($urandom));
                1: send(ACT_RETRY, order[k], DEP_W'($urandom));
                2: send(ACT_RESUME, $urandom_range(0, 15), DEP_W'($urandom));
                3: send(3'($urandom_range(0, 7)), $urandom_range(0, 15), DEP_W'($urandom));
                default:
                begin
                end
            endcase
            send(ACT_FINISH, order[k], DEP_W'($urandom));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed walk through the special cases.
        send(ACT_CLEAR, 0, '0);
        send(ACT_RESUME, 0, '0);          // empty table: no finished result
        send(ACT_FINISH, 3, '0);          // absent slot ignored
        send(ACT_FAIL, 0, '0);            // absent slot ignored
        send(ACT_RETRY, 15, 16'hFFFF);    // absent slot ignored
        send(ACT_ADD, 0, '0);
        send(ACT_ADD, 1, 16'h0001);
        send(ACT_ADD, 2, 16'h0004);       // depends on itself
        send(ACT_ADD, 15, 16'hFFFF);
        send(3'd6, 5, 16'h5555);          // unused action codes
        send(3'd7, 15, 16'hFFFF);
        send(ACT_RESUME, 0, '0);
        send(ACT_FINISH, 0, '0);
        send(ACT_FINISH, 0, '0);          // already complete
        send(ACT_FAIL, 1, '0);
        send(ACT_FINISH, 1, '0);          // failed slot completes
        send(ACT_RETRY, 0, '0);
        send(ACT_ADD, 2, '0);             // overwrite with no dependencies
        send(ACT_FINISH, 2, '0);
        send(ACT_FINISH, 0, '0);
        send(ACT_FINISH, 15, '0);         // last one: workflow finished
        send(ACT_ADD, 4, '0);
        send(ACT_CLEAR, 4, '0);
        send(ACT_RESUME, 0, 16'hAAAA);

        // Random workflows with some noise between them.
        while (issued < ITEM_GOAL)
        begin
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3))
                    send(3'($urandom_range(0, 7)), $urandom_range(0, 15), DEP_W'($urandom));
            else
                run_workflow();
        end

        // Drain and give the verdict.
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0 || busy)
            @(negedge clk);
        repeat (SLOTS + 8) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
